FILE: hdl/rgen_pkg.sv
package rgen_pkg;

  // levels are unsigned Q32 with one integer bit, 1.0 = 2^32
  localparam int LvlW = 33;
  localparam logic [LvlW-1:0] ONE_Q32 = 33'h1_0000_0000;

  typedef struct packed {
    logic            valid;
    logic [LvlW-1:0] level;
  } lvl_tag_t;

endpackage

FILE: hdl/gamma_ramp_entry_generator_core.sv
// channel | direction | handshake            | payload
// input   | in        | in_valid / in_ready  | ramp_index
// output  | out       | out_valid / out_ready| ramp_value
// config  | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// one item per clock unless the output stalls; the pipeline runs front, log2, exp2, then output
// the log2 is 32 squaring stages and the exp2 a series to the 13th power, 3 stages a term
// a stalled output freezes the whole pipeline; in_ready follows that enable
// rst (synchronous) clears valid bits and loads the default gamma and contrast
// cfg_ready is always high; a write to an unused index is dropped
module gamma_ramp_entry_generator_core import rgen_pkg::*; #(
  parameter int INDEX_BITS = 8,
  parameter int OUT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] ramp_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_BITS-1:0]   ramp_value,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_data
);

  typedef enum logic [1:0] {
    REG_GAMMA      = 2'd0,
    REG_BRIGHTNESS = 2'd1,
    REG_CONTRAST   = 2'd2
  } cfg_reg_t;

  localparam logic [15:0] GAMMA_UNIT = 16'd4096;
  localparam logic [OUT_BITS-1:0] OUT_MAX = '1;

  logic [15:0]        gamma_q12;
  logic signed [15:0] brightness_q14;
  logic [15:0]        contrast_q12;

  logic            en;
  lvl_tag_t        front_tag, log_tag, exp_tag;
  logic [5:0]      nl_int;
  logic [31:0]     nl_frac;
  logic [LvlW-1:0] r_exp;

  logic                     sel_valid;
  logic [LvlW-1:0]          r_sel, r_next;
  logic [LvlW+OUT_BITS-1:0] scaled;

  assign cfg_ready = 1'b1;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      gamma_q12      <= GAMMA_UNIT;
      brightness_q14 <= '0;
      contrast_q12   <= GAMMA_UNIT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GAMMA:      gamma_q12 <= cfg_data;
        REG_BRIGHTNESS: brightness_q14 <= $signed(cfg_data);
        REG_CONTRAST:   contrast_q12 <= cfg_data;
        default: ;
      endcase
    end
  end

  rgen_front #(.INDEX_BITS(INDEX_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .idx        (ramp_index),
    .brightness (brightness_q14),
    .contrast   (contrast_q12),
    .tag_o      (front_tag)
  );

  rgen_log2 u_log2 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_i   (front_tag),
    .tag_o   (log_tag),
    .nl_int  (nl_int),
    .nl_frac (nl_frac)
  );

  rgen_exp2 u_exp2 (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_i   (log_tag),
    .nl_int  (nl_int),
    .nl_frac (nl_frac),
    .gamma   (gamma_q12),
    .tag_o   (exp_tag),
    .r_o     (r_exp)
  );

  // zero gamma, zero level, full level and unit gamma bypass the power
  always_comb begin
    if (gamma_q12 == '0) begin
      r_next = ONE_Q32;
    end else if (exp_tag.level == '0) begin
      r_next = '0;
    end else if (exp_tag.level == ONE_Q32 || gamma_q12 == GAMMA_UNIT) begin
      r_next = exp_tag.level;
    end else begin
      r_next = r_exp;
    end
  end

  assign scaled = r_sel * OUT_MAX;

  always_ff @(posedge clk) begin
    if (rst) begin
      sel_valid <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      sel_valid  <= exp_tag.valid;
      r_sel      <= r_next;
      out_valid  <= sel_valid;
      ramp_value <= scaled[LvlW+OUT_BITS-2:LvlW-1];
    end
  end

  a_stall_holds_sel: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(r_sel) && $stable(sel_valid))
    else $error("select stage moved during output stall");

  a_sel_in_range: assert property (@(posedge clk) disable iff (rst)
    sel_valid |-> r_sel <= ONE_Q32)
    else $error("selected power above full scale");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    sel_valid && !en |=> sel_valid)
    else $error("item lost in select stage while stalled");

endmodule

FILE: hdl/rgen_front.sv
module rgen_front import rgen_pkg::*; #(
  parameter int INDEX_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [INDEX_BITS-1:0] idx,
  input  logic signed [15:0]    brightness,
  input  logic [15:0]           contrast,
  output lvl_tag_t              tag_o
);

  localparam logic [INDEX_BITS-1:0] IDX_MAX = '1;
  localparam logic signed [35:0] HALF_Q32 = 36'sh0_8000_0000;
  localparam logic signed [53:0] HALF_Q44 = 54'sh0_0800_0000_0000;
  localparam logic signed [53:0] ONE_Q44  = 54'sh0_1000_0000_0000;

  logic                   s1_valid, s2_valid, s3_valid;
  logic [LvlW-1:0]        x1, x_next;
  logic signed [35:0]     v2, v_next;
  logic signed [53:0]     t3, t_next;
  logic [LvlW-1:0]        y_next;

  // idx / (2^N - 1) in binary is idx repeated, except full scale
  always_comb begin
    x_next = '0;
    if (idx == IDX_MAX) begin
      x_next = ONE_Q32;
    end else begin
      for (int j = 0; j < 32; j++) begin
        x_next[31-j] = idx[INDEX_BITS-1-(j % INDEX_BITS)];
      end
    end
  end

  always_comb begin
    v_next = $signed({3'b000, x1}) + ($signed(36'(brightness)) <<< 18) - HALF_Q32;
  end

  always_comb begin
    t_next = v2 * $signed({1'b0, contrast}) + HALF_Q44;
  end

  always_comb begin
    if (t3 <= 54'sd0) begin
      y_next = '0;
    end else if (t3 >= ONE_Q44) begin
      y_next = ONE_Q32;
    end else begin
      y_next = {1'b0, t3[43:12]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      s3_valid    <= 1'b0;
      tag_o.valid <= 1'b0;
    end else if (en) begin
      s1_valid    <= in_valid;
      x1          <= x_next;
      s2_valid    <= s1_valid;
      v2          <= v_next;
      s3_valid    <= s2_valid;
      t3          <= t_next;
      tag_o.valid <= s3_valid;
      tag_o.level <= y_next;
    end
  end

endmodule

FILE: hdl/rgen_log2.sv
module rgen_log2 import rgen_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  lvl_tag_t    tag_i,
  output lvl_tag_t    tag_o,
  output logic [5:0]  nl_int,
  output logic [31:0] nl_frac
);

  localparam int Steps = 32;

  lvl_tag_t    lz_tag;
  logic [4:0]  lz, lz_next;

  lvl_tag_t    tg [0:Steps];
  logic [31:0] m  [0:Steps];
  logic [31:0] fr [0:Steps];
  logic [4:0]  ex [0:Steps];

  logic [37:0] nl_next;

  // leading zero count of the 32-bit fraction
  always_comb begin
    lz_next = '0;
    for (int i = 0; i < 32; i++) begin
      if (tag_i.level[i]) lz_next = 5'(31 - i);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lz_tag.valid <= 1'b0;
      tg[0].valid  <= 1'b0;
    end else if (en) begin
      lz_tag <= tag_i;
      lz     <= lz_next;
      tg[0]  <= lz_tag;
      m[0]   <= lz_tag.level[31:0] << lz;
      fr[0]  <= '0;
      ex[0]  <= lz;
    end
  end

  // one squaring per stage gives one fraction bit of the log
  for (genvar k = 0; k < Steps; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] sh;
    logic [31:0] m_next;
    logic        bit_next;

    always_comb begin
      sq = m[k] * m[k];
      sh = sq[63:31];
      bit_next = sh[32];
      m_next = sh[32] ? sh[32:1] : sh[31:0];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[k+1].valid <= 1'b0;
      end else if (en) begin
        tg[k+1] <= tg[k];
        m[k+1]  <= m_next;
        fr[k+1] <= {fr[k][30:0], bit_next};
        ex[k+1] <= ex[k];
      end
    end
  end

  always_comb begin
    nl_next = {6'({1'b0, ex[Steps]}) + 6'd1, 32'd0} - {6'd0, fr[Steps]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else if (en) begin
      tag_o   <= tg[Steps];
      nl_int  <= nl_next[37:32];
      nl_frac <= nl_next[31:0];
    end
  end

endmodule

FILE: hdl/rgen_exp2.sv
module rgen_exp2 import rgen_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  lvl_tag_t        tag_i,
  input  logic [5:0]      nl_int,
  input  logic [31:0]     nl_frac,
  input  logic [15:0]     gamma,
  output lvl_tag_t        tag_o,
  output logic [LvlW-1:0] r_o
);

  localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;
  localparam int Terms = 13;
  localparam int RecipShift = 35;

  typedef struct packed {
    lvl_tag_t    tag;
    logic [9:0]  k;
    logic [31:0] zv;
    logic [33:0] pos;
    logic [33:0] neg;
    logic [31:0] work;
    logic [31:0] quot;
  } ser_t;

  lvl_tag_t    g_tag, e_tag;
  logic [47:0] pa;
  logic [21:0] pb;
  logic [53:0] e_sum;
  logic [9:0]  e_k;
  logic [31:0] e_f;
  logic [63:0] z_prod;

  ser_t sa [2:Terms];
  ser_t sb [2:Terms];
  ser_t sc [1:Terms];

  logic [33:0]     rr;
  logic [LvlW-1:0] r_next;

  always_comb begin
    e_sum = {pb, 32'd0} + {6'd0, pa};
    z_prod = e_f * LN2_Q32;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_tag.valid     <= 1'b0;
      e_tag.valid     <= 1'b0;
      sc[1].tag.valid <= 1'b0;
    end else if (en) begin
      g_tag <= tag_i;
      pa    <= gamma * nl_frac;
      pb    <= gamma * nl_int;
      e_tag <= g_tag;
      e_k   <= e_sum[53:44];
      e_f   <= e_sum[43:12];
      sc[1].tag  <= e_tag;
      sc[1].k    <= e_k;
      sc[1].zv   <= z_prod[63:32];
      sc[1].pos  <= {2'b00, ONE_Q32[31:0]} | 34'h1_0000_0000;
      sc[1].neg  <= {2'b00, z_prod[63:32]};
      sc[1].work <= z_prod[63:32];
      sc[1].quot <= '0;
    end
  end

  // each term: multiply by z, divide by n via reciprocal, then correct and add
  for (genvar g = 2; g <= Terms; g++) begin : g_term
    localparam int N = g;
    localparam logic [34:0] RECIP = 35'((64'd1 << RecipShift) / N);
    localparam logic [3:0]  NC = 4'(N);

    logic [63:0] pr_a;
    logic [66:0] pr_b;
    logic [35:0] qn;
    logic [35:0] rem;
    logic [31:0] q;
    ser_t        a_next, b_next, c_next;

    always_comb begin
      a_next = sc[g-1];
      pr_a = sc[g-1].work * sc[g-1].zv;
      a_next.work = pr_a[63:32];

      b_next = sa[g];
      pr_b = sa[g].work * RECIP;
      b_next.quot = pr_b[66:35];

      c_next = sb[g];
      qn = sb[g].quot * NC;
      rem = {4'd0, sb[g].work} - qn;
      q = (rem >= 36'(NC)) ? sb[g].quot + 32'd1 : sb[g].quot;
      c_next.work = q;
      if ((N % 2) == 1) begin
        c_next.neg = sb[g].neg + {2'b00, q};
      end else begin
        c_next.pos = sb[g].pos + {2'b00, q};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        sa[g].tag.valid <= 1'b0;
        sb[g].tag.valid <= 1'b0;
        sc[g].tag.valid <= 1'b0;
      end else if (en) begin
        sa[g] <= a_next;
        sb[g] <= b_next;
        sc[g] <= c_next;
      end
    end
  end

  always_comb begin
    rr = (sc[Terms].pos > sc[Terms].neg) ? sc[Terms].pos - sc[Terms].neg : '0;
    if (rr > {1'b0, ONE_Q32}) rr = {1'b0, ONE_Q32};
    if (sc[Terms].k > 10'd32) begin
      r_next = '0;
    end else begin
      r_next = rr[LvlW-1:0] >> sc[Terms].k;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_o.valid <= 1'b0;
    end else if (en) begin
      tag_o <= sc[Terms].tag;
      r_o   <= r_next;
    end
  end

endmodule
